FILE: src/sfp_pkg.sv
package sfp_pkg;

    localparam int MAX_LEN   = 32;
    localparam int LEN_W     = 6;
    localparam int VIS_BYTES = 7;

    localparam logic [7:0] SYNC1_BYTE   = 8'hAA;
    localparam logic [7:0] SYNC2_BYTE   = 8'h55;
    localparam logic [7:0] CR_BYTE      = 8'h0D;
    localparam logic [7:0] LF_BYTE      = 8'h0A;
    localparam logic [7:0] TYPE_VISION  = 8'h01;
    localparam logic [7:0] TYPE_CMD     = 8'h02;
    localparam logic [7:0] CMD_START    = 8'h01;
    localparam logic [7:0] CMD_MIS_LO   = 8'h11;
    localparam logic [7:0] CMD_MIS_HI   = 8'h14;
    localparam logic [7:0] CH_MIS_1     = 8'h31;
    localparam logic [7:0] CH_MIS_2     = 8'h32;
    localparam logic [7:0] CH_MIS_3     = 8'h33;
    localparam logic [7:0] CH_MIS_4     = 8'h34;
    localparam logic [7:0] CH_START_LC  = 8'h73;
    localparam logic [7:0] CH_START_UC  = 8'h53;
    localparam logic [7:0] CH_STOP_LC   = 8'h78;
    localparam logic [7:0] CH_STOP_UC   = 8'h58;

    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_VISION  = 3'd1;
    localparam logic [2:0] EV_START   = 3'd2;
    localparam logic [2:0] EV_MISSION = 3'd3;
    localparam logic [2:0] EV_STOP    = 3'd4;

    typedef enum logic [2:0] {
        PH_SYNC1 = 3'd0,
        PH_SYNC2 = 3'd1,
        PH_LEN   = 3'd2,
        PH_TYPE  = 3'd3,
        PH_DATA  = 3'd4,
        PH_CSUM  = 3'd5,
        PH_CR    = 3'd6,
        PH_LF    = 3'd7
    } phase_t;

    typedef struct packed {
        logic [2:0]         event_kind;
        logic [2:0]         mission_number;
        logic signed [15:0] target_x;
        logic signed [15:0] target_y;
        logic [7:0]         class_code;
        logic [15:0]        blob_area;
    } event_t;

endpackage

FILE: src/sfp_byte_if.sv
interface sfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: src/sfp_event_if.sv
interface sfp_event_if;
    logic               valid;
    logic               ready;
    logic [2:0]         event_kind;
    logic [2:0]         mission_number;
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
    logic [7:0]         class_code;
    logic [15:0]        blob_area;

    modport source (output valid, output event_kind, output mission_number,
                    output target_x, output target_y, output class_code,
                    output blob_area, input ready);
    modport sink (input valid, input event_kind, input mission_number,
                  input target_x, input target_y, input class_code,
                  input blob_area, output ready);
endinterface

FILE: src/sfp_parser.sv
module sfp_parser
    import sfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_en,
    input  logic [7:0] rx_byte,
    output event_t     result
);

    phase_t           phase_reg, phase_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [7:0]       type_reg, type_next;
    logic [LEN_W-1:0] idx_reg, idx_next;
    logic [7:0]       xor_reg, xor_next;
    logic [7:0]       pay_reg [VIS_BYTES];
    logic [LEN_W-1:0] idx_inc;
    logic             is_cmd;
    logic             pay_wr;

    assign idx_inc = idx_reg + LEN_W'(1);

    always_comb
    begin
        unique case (rx_byte) inside
            CH_MIS_1, CH_MIS_2, CH_MIS_3, CH_MIS_4,
            CH_START_LC, CH_START_UC, CH_STOP_LC, CH_STOP_UC: is_cmd = 1'b1;
            default: is_cmd = 1'b0;
        endcase
    end

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        type_next  = type_reg;
        idx_next   = idx_reg;
        xor_next   = xor_reg;
        pay_wr     = 1'b0;
        if (is_cmd)
        begin
            phase_next = PH_SYNC1;
        end
        else
        begin
            unique case (phase_reg)
                PH_SYNC1:
                begin
                    if (rx_byte == SYNC1_BYTE)
                        phase_next = PH_SYNC2;
                end
                PH_SYNC2:
                begin
                    phase_next = (rx_byte == SYNC2_BYTE) ? PH_LEN : PH_SYNC1;
                end
                PH_LEN:
                begin
                    if (rx_byte == 8'd0 || rx_byte > 8'(MAX_LEN))
                    begin
                        phase_next = PH_SYNC1;
                    end
                    else
                    begin
                        len_next   = rx_byte[LEN_W-1:0];
                        xor_next   = rx_byte;
                        phase_next = PH_TYPE;
                    end
                end
                PH_TYPE:
                begin
                    type_next  = rx_byte;
                    xor_next   = xor_reg ^ rx_byte;
                    idx_next   = '0;
                    phase_next = PH_DATA;
                end
                PH_DATA:
                begin
                    pay_wr   = 1'b1;
                    idx_next = idx_inc;
                    xor_next = xor_reg ^ rx_byte;
                    if (idx_inc >= len_reg)
                        phase_next = PH_CSUM;
                end
                PH_CSUM:
                begin
                    phase_next = (rx_byte == xor_reg) ? PH_CR : PH_SYNC1;
                end
                PH_CR:
                begin
                    phase_next = (rx_byte == CR_BYTE) ? PH_LF : PH_SYNC1;
                end
                PH_LF:
                begin
                    phase_next = PH_SYNC1;
                end
                default:
                begin
                    phase_next = PH_SYNC1;
                end
            endcase
        end
    end

    // outputs
    always_comb
    begin
        result = '0;
        if (is_cmd)
        begin
            case (rx_byte) inside
                CH_START_LC, CH_START_UC: result.event_kind = EV_START;
                CH_STOP_LC, CH_STOP_UC:   result.event_kind = EV_STOP;
                default:
                begin
                    result.event_kind     = EV_MISSION;
                    result.mission_number = rx_byte[2:0];
                end
            endcase
        end
        else if (phase_reg == PH_LF && rx_byte == LF_BYTE)
        begin
            if (type_reg == TYPE_VISION && len_reg >= LEN_W'(VIS_BYTES))
            begin
                result.event_kind = EV_VISION;
                result.target_x   = {pay_reg[1], pay_reg[0]};
                result.target_y   = {pay_reg[3], pay_reg[2]};
                result.class_code = pay_reg[4];
                result.blob_area  = {pay_reg[6], pay_reg[5]};
            end
            else if (type_reg == TYPE_CMD)
            begin
                if (pay_reg[0] == CMD_START)
                begin
                    result.event_kind = EV_START;
                end
                else if (pay_reg[0] >= CMD_MIS_LO && pay_reg[0] <= CMD_MIS_HI)
                begin
                    result.event_kind     = EV_MISSION;
                    result.mission_number = pay_reg[0][2:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SYNC1;
            len_reg   <= '0;
            type_reg  <= '0;
            idx_reg   <= '0;
            xor_reg   <= '0;
        end
        else if (byte_en)
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            type_reg  <= type_next;
            idx_reg   <= idx_next;
            xor_reg   <= xor_next;
        end
    end

    // only the leading payload bytes are ever decoded
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < VIS_BYTES; i++)
        begin
            if (byte_en && pay_wr && idx_reg == LEN_W'(i))
                pay_reg[i] <= rx_byte;
        end
    end

endmodule

FILE: src/sfp_out_buf.sv
module sfp_out_buf
    import sfp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  event_t push_data,
    output logic   push_ready,
    output logic   out_valid,
    output event_t out_data,
    input  logic   out_ready
);

    logic   out_valid_reg, out_valid_next;
    logic   skid_valid_reg, skid_valid_next;
    event_t out_reg, out_next;
    event_t skid_reg, skid_next;

    assign push_ready = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = push;
                out_next       = push_data;
            end
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_next       = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

endmodule

FILE: src/serial_frame_parser_xor.sv
// Serial frame parser. Every received byte yields exactly one event word, which
// is registered in the output buffer; most carry event_kind 0 (none). Command
// characters '1'..'4', 's'/'S' and 'x'/'X' report at once and drop any frame
// in progress. Frames are AA 55, length 1..32, type, payload, XOR checksum of
// length, type and payload, CR, LF; the event is reported on the LF byte.
// Throughput is one byte per clock while the output buffer has room: the parser
// state advances on every accepted byte, and a two-entry output buffer keeps rx
// ready through one stalled event word.
module serial_frame_parser_xor
    import sfp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    sfp_byte_if.sink   rx,
    sfp_event_if.source evt
);

    logic   byte_en;
    logic   buf_ready;
    event_t result;
    event_t out_data;

    assign rx.ready = buf_ready;
    assign byte_en  = rx.valid && buf_ready;

    sfp_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_en (byte_en),
        .rx_byte (rx.rx_byte),
        .result  (result)
    );

    sfp_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (byte_en),
        .push_data  (result),
        .push_ready (buf_ready),
        .out_valid  (evt.valid),
        .out_data   (out_data),
        .out_ready  (evt.ready)
    );

    assign evt.event_kind     = out_data.event_kind;
    assign evt.mission_number = out_data.mission_number;
    assign evt.target_x       = out_data.target_x;
    assign evt.target_y       = out_data.target_y;
    assign evt.class_code     = out_data.class_code;
    assign evt.blob_area      = out_data.blob_area;

endmodule
